[src/pnpr_pkg.sv]
// shared constants, widths and register codes for the pixel normalize / patch reshape block
// no dependencies; imported by pnpr_norm and pixel_normalize_patch_reshape
package pnpr_pkg;

  // storage bounds of the patch-unfolded layout
  localparam int MAX_PATCHES    = 1024;
  localparam int MAX_PATCH_SIZE = 32;

  // field widths
  localparam int PIX_W   = 8;
  localparam int GAIN_W  = 16;
  localparam int OFF_W   = 21;
  localparam int NORM_W  = 16;
  localparam int ROW_W   = 5;
  localparam int SCOL_W  = 15;
  localparam int CFG_W   = 21;
  localparam int CIDX_W  = 3;

  // position counter widths
  localparam int PSZ_W   = $clog2(MAX_PATCH_SIZE + 1);
  localparam int CNT_W   = $clog2(MAX_PATCH_SIZE);
  localparam int WIP_W   = $clog2(MAX_PATCHES + 1);
  localparam int PCOL_W  = $clog2(MAX_PATCHES);
  localparam int BASE_W  = 16;
  localparam int PIDX_W  = BASE_W + 1;

  // register reset values
  localparam logic [GAIN_W-1:0] GAIN_RST  = GAIN_W'(1028);
  localparam logic [OFF_W-1:0]  OFF_RST   = OFF_W'(-65536);
  localparam logic [5:0]        PSZ_RST   = 6'd14;
  localparam logic [10:0]       WIP_RST   = 11'd1;

  // configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_GAIN_RED     = 3'd0,
    REG_GAIN_GREEN   = 3'd1,
    REG_GAIN_BLUE    = 3'd2,
    REG_OFFSET_RED   = 3'd3,
    REG_OFFSET_GREEN = 3'd4,
    REG_OFFSET_BLUE  = 3'd5,
    REG_PATCH_SIZE   = 3'd6,
    REG_WIDTH_PATCH  = 3'd7
  } cfg_reg_t;

endpackage

[src/pnpr_norm.sv]
// one channel of the normalizer: pix*gain + offset, round half up to Q4.12, saturate
// depends on pnpr_pkg for field widths
module pnpr_norm (
  input  logic [pnpr_pkg::PIX_W-1:0]         pix,
  input  logic [pnpr_pkg::GAIN_W-1:0]        gain,
  input  logic signed [pnpr_pkg::OFF_W-1:0]  offset,
  output logic signed [pnpr_pkg::NORM_W-1:0] norm
);
  import pnpr_pkg::*;

  localparam int PROD_W = PIX_W + GAIN_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int Q_W    = SUM_W - 4;

  logic [PROD_W-1:0]       prod;
  logic signed [SUM_W-1:0] sum;
  logic signed [Q_W-1:0]   q;

  // Q.16 sum with the rounding half step, then drop four fraction bits
  assign prod = PROD_W'(pix) * PROD_W'(gain);
  assign sum  = $signed({2'b00, prod}) + SUM_W'(offset) + SUM_W'(8);
  assign q    = Q_W'(sum >>> 4);

  // clamp to the signed 16-bit range
  always_comb begin
    if (q > Q_W'(32767)) begin
      norm = NORM_W'(32767);
    end else if (q < -Q_W'(32768)) begin
      norm = NORM_W'(-32768);
    end else begin
      norm = NORM_W'(q);
    end
  end

endmodule

[src/pixel_normalize_patch_reshape.sv]
// top level: pixel normalizer with patch-unfold addressing, two register stages
// depends on pnpr_pkg and pnpr_norm
//
// Takes one RGB pixel per clock in raster order and returns one result per
// pixel. The result passes from the stage one register into the output
// register, and with out_tready high it leaves from there. One pixel per
// clock is kept as long as the output side takes results. Stage one
// captures the pixel together with its patch position (position counters
// advance at input acceptance, a set in_tuser bit restarts them first); stage
// two runs the three 8x16 channel multiplies and the patch index times patch
// size product. A stage stalls only when full and unable to pass on, so a held
// output only blocks the input when both stages are full. Configuration writes
// are always taken (cfg_ready is high) and must only be issued while the block is idle.
module pixel_normalize_patch_reshape (
  input  logic        clk,
  input  logic        rst_n,
  // input pixel requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
  input  logic [0:0]  in_tuser,   // start_of_image[0]
  // result requests
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // norm_red[15:0], norm_green[31:16], norm_blue[47:32],
                                  // strip_row[52:48], strip_col[67:53], zero pad[71:68]
  output logic [0:0]  out_tuser,  // index_overflow[0]
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pnpr_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [pnpr_pkg::CFG_W-1:0]    cfg_data
);
  import pnpr_pkg::*;

  // configuration registers
  logic [GAIN_W-1:0]       gain_r [3];
  logic signed [OFF_W-1:0] off_r  [3];
  logic [5:0]              psz_r;
  logic [10:0]             wip_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '{GAIN_RST, GAIN_RST, GAIN_RST};
      off_r  <= '{OFF_RST, OFF_RST, OFF_RST};
      psz_r  <= PSZ_RST;
      wip_r  <= WIP_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_GAIN_RED:     gain_r[0] <= cfg_data[GAIN_W-1:0];
        REG_GAIN_GREEN:   gain_r[1] <= cfg_data[GAIN_W-1:0];
        REG_GAIN_BLUE:    gain_r[2] <= cfg_data[GAIN_W-1:0];
        REG_OFFSET_RED:   off_r[0]  <= cfg_data[OFF_W-1:0];
        REG_OFFSET_GREEN: off_r[1]  <= cfg_data[OFF_W-1:0];
        REG_OFFSET_BLUE:  off_r[2]  <= cfg_data[OFF_W-1:0];
        REG_PATCH_SIZE:   psz_r     <= cfg_data[5:0];
        REG_WIDTH_PATCH:  wip_r     <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // effective patch size and width, zero acts as one, clipped to the bounds
  logic [PSZ_W-1:0] ps_eff;
  logic [WIP_W-1:0] wp_eff;

  always_comb begin
    if (psz_r == '0) begin
      ps_eff = PSZ_W'(1);
    end else if (7'(psz_r) > 7'(MAX_PATCH_SIZE)) begin
      ps_eff = PSZ_W'(MAX_PATCH_SIZE);
    end else begin
      ps_eff = PSZ_W'(psz_r);
    end
    if (wip_r == '0) begin
      wp_eff = WIP_W'(1);
    end else if (12'(wip_r) > 12'(MAX_PATCHES)) begin
      wp_eff = WIP_W'(MAX_PATCHES);
    end else begin
      wp_eff = WIP_W'(wip_r);
    end
  end

  // pipeline handshake
  logic s1_valid_r;
  logic s2_load, s1_load;

  assign s2_load   = s1_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !s1_valid_r || s2_load;
  assign s1_load   = in_tvalid && in_tready;

  // position counters
  logic [CNT_W-1:0]  col_r, row_r;
  logic [PCOL_W-1:0] pcol_r;
  logic [BASE_W-1:0] base_r;
  logic [CNT_W-1:0]  col_cur, row_cur;
  logic [PCOL_W-1:0] pcol_cur;
  logic [BASE_W-1:0] base_cur;
  logic [PIDX_W-1:0] pidx;
  logic              ovf;
  logic [PIDX_W-1:0] base_sum;
  logic [CNT_W-1:0]  col_nxt, row_nxt;
  logic [PCOL_W-1:0] pcol_nxt;
  logic [BASE_W-1:0] base_nxt;

  always_comb begin
    if (in_tuser[0]) begin
      col_cur  = '0;
      row_cur  = '0;
      pcol_cur = '0;
      base_cur = '0;
    end else begin
      col_cur  = col_r;
      row_cur  = row_r;
      pcol_cur = pcol_r;
      base_cur = base_r;
    end

    pidx     = PIDX_W'(base_cur) + PIDX_W'(pcol_cur);
    ovf      = pidx >= PIDX_W'(MAX_PATCHES);
    base_sum = PIDX_W'(base_cur) + PIDX_W'(wp_eff);

    // raster advance: column in patch, then patch column, then row, then patch row
    col_nxt  = col_cur + CNT_W'(1);
    row_nxt  = row_cur;
    pcol_nxt = pcol_cur;
    base_nxt = base_cur;
    if ((PSZ_W'(col_cur) + PSZ_W'(1)) >= ps_eff) begin
      col_nxt = '0;
      if ((WIP_W'(pcol_cur) + WIP_W'(1)) >= wp_eff) begin
        pcol_nxt = '0;
        if ((PSZ_W'(row_cur) + PSZ_W'(1)) >= ps_eff) begin
          row_nxt = '0;
          if (base_sum[PIDX_W-1]) begin
            base_nxt = '1;
          end else begin
            base_nxt = base_sum[BASE_W-1:0];
          end
        end else begin
          row_nxt = row_cur + CNT_W'(1);
        end
      end else begin
        pcol_nxt = pcol_cur + PCOL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      pcol_r <= '0;
      base_r <= '0;
    end else if (s1_load) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pcol_r <= pcol_nxt;
      base_r <= base_nxt;
    end
  end

  // stage one: pixel and position
  logic [23:0]       s1_pix_r;
  logic [CNT_W-1:0]  s1_col_r, s1_row_r;
  logic [PCOL_W-1:0] s1_pidx_r;
  logic [PSZ_W-1:0]  s1_ps_r;
  logic              s1_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (s2_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_pix_r  <= in_tdata;
      s1_col_r  <= col_cur;
      s1_row_r  <= row_cur;
      s1_pidx_r <= pidx[PCOL_W-1:0];
      s1_ps_r   <= ps_eff;
      s1_ovf_r  <= ovf;
    end
  end

  // stage two: channel normalize and strip column
  logic signed [NORM_W-1:0] norm [3];

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    pnpr_norm u_norm (
      .pix    (s1_pix_r[ch*PIX_W +: PIX_W]),
      .gain   (gain_r[ch]),
      .offset (off_r[ch]),
      .norm   (norm[ch])
    );
  end

  localparam int SPROD_W = PCOL_W + PSZ_W + 1;
  logic [SPROD_W-1:0] scol_full;
  logic [SCOL_W-1:0]  scol;

  assign scol_full = SPROD_W'(s1_pidx_r) * SPROD_W'(s1_ps_r) + SPROD_W'(s1_col_r);
  assign scol      = s1_ovf_r ? '0 : scol_full[SCOL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (s2_load) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_tdata <= {4'b0000, scol, ROW_W'(s1_row_r), norm[2], norm[1], norm[0]};
      out_tuser <= s1_ovf_r;
    end
  end

`ifndef ASSERT_OFF
  // an overflowed patch index always carries a zero strip column
  a_ovf_zero_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[67:53] == '0)
    else $error("strip column not zero on index overflow");

  // a start of image puts the pixel at the origin of the strip
  a_start_origin: assert property (@(posedge clk) disable iff (!rst_n)
    s1_load && in_tuser[0] |=> s1_col_r == '0 && s1_row_r == '0 && s1_pidx_r == '0)
    else $error("start of image did not restart position");

  // a held stage one pixel is not dropped while the output stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_load |=> s1_valid_r && $stable(s1_pix_r))
    else $error("stage one pixel lost under stall");

  // a stage one pixel only moves into an empty or draining output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load |-> !out_tvalid || out_tready)
    else $error("output register overwritten");
`endif

endmodule

[tb/sv/pixel_normalize_patch_reshape_tb.sv]
// self-checking testbench for pixel_normalize_patch_reshape: pixel requests in, results checked
// against a cycle-free predictor of channel normalization and patch-unfold placement, or typed goldens
// depends on pnpr_pkg and the pixel_normalize_patch_reshape top level
module pixel_normalize_patch_reshape_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pnpr_pkg::*;

  localparam int HOLD_CYCLES = 48;
  localparam int PHASES      = 12;
  localparam int N_DIRECTED  = 35;

  // one normalized pixel with its strip position
  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [4:0]  row;
    logic [14:0] col;
    logic        ovf;
  } norm_result_t;

  typedef enum logic [0:0] {ROW_PIXEL, ROW_WRITE} row_kind_t;

  // directed stimulus row: a pixel request or a register write
  typedef struct packed {
    row_kind_t    kind;
    cfg_reg_t     reg_idx;
    logic [20:0]  value;
    logic         sof;
    logic [7:0]   red;
    logic [7:0]   green;
    logic [7:0]   blue;
    logic         typed;
    norm_result_t golden;
  } stim_row_t;

  localparam norm_result_t UNTYPED = '0;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // red_in[7:0], green_in[15:8], blue_in[23:16]
  logic [0:0]  in_tuser;   // start_of_image[0]
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // norm_red, norm_green, norm_blue, strip_row, strip_col, pad
  logic [0:0]  out_tuser;  // index_overflow[0]
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  // register copies and position counters of the predictor
  logic [15:0] gain_q [3];
  logic [20:0] offset_q [3];
  logic [5:0]  patch_reg;
  logic [10:0] width_reg;
  int          px_col, px_patch_col, px_row, px_row_base;

  norm_result_t expected_norm [$];
  int           miss_count = 0;
  bit           source_gaps = 1'b1;
  bit           sink_gaps = 1'b1;
  bit           hold_req = 1'b0;

  pixel_normalize_patch_reshape dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // directed table: reset defaults, register extremes, rounding ties, counters past new bounds
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_PIXEL, REG_GAIN_RED, 21'd0, 1'b1, 8'd0, 8'd0, 8'd0, 1'b1,
      '{16'hF000, 16'hF000, 16'hF000, 5'd0, 15'd0, 1'b0}},
    '{ROW_PIXEL, REG_GAIN_RED, 21'd0, 1'b0, 8'd255, 8'd255, 8'd255, 1'b1,
      '{16'h3000, 16'h3000, 16'h3000, 5'd0, 15'd1, 1'b0}},
    '{ROW_PIXEL, REG_GAIN_RED, 21'd0, 1'b0, 8'd128, 8'd1, 8'd254, 1'b0, UNTYPED},
    '{ROW_WRITE, REG_GAIN_RED, 21'd65535, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, UNTYPED},
    '{ROW_WRITE, REG_GAIN_GREEN, 21'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, UNTYPED},
    '{ROW_WRITE, REG_GAIN_BLUE, 21'd32768, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, UNTYPED},
    '{ROW_WRITE, REG_OFFSET_RED, 21'h0FFFFF, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, UNTYPED},
    '{ROW_WRITE, REG_OFFSET_GREEN, 21'h100000, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, UNTYPED},
    '{ROW_WRITE, REG_OFFSET_BLUE, 21'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, UNTYPED},
    '{ROW_WRITE, REG_PATCH_SIZE, 21'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, UNTYPED},
    '{ROW_WRITE, REG_WIDTH_PATCH, 21'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, UNTYPED},
    '{ROW_PIXEL, REG_GAIN_RED, 21'd0, 1'b1, 8'd255, 8'd0, 8'd255, 1'b1,
      '{16'h7FFF, 16'h8000, 16'h7FFF, 5'd0, 15'd0, 1'b0}},
    '{ROW_PIXEL, REG_GAIN_RED, 21'd0, 1'b0, 8'd0, 8'd255, 8'd0, 1'b1,
      '{16'h7FFF, 16'h8000, 16'h0000, 5'd0, 15'd1, 1'b0}},
    '{ROW_WRITE, REG_GAIN_RED, 21'd8, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, UNTYPED},
    '{ROW_WRITE, REG_GAIN_BLUE, 21'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, UNTYPED},
    '{ROW_WRITE, REG_OFFSET_RED, 21'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, UNTYPED},
    '{ROW_WRITE, REG_OFFSET_GREEN, 21'h1FFFF8, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, UNTYPED},
    '{ROW_WRITE, REG_OFFSET_BLUE, 21'h1FFFE8, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, UNTYPED},
    '{ROW_WRITE, REG_PATCH_SIZE, 21'd63, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, UNTYPED},
    '{ROW_WRITE, REG_WIDTH_PATCH, 21'd2047, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, UNTYPED},
    '{ROW_PIXEL, REG_GAIN_RED, 21'd0, 1'b1, 8'd1, 8'd0, 8'd0, 1'b1,
      '{16'h0001, 16'h0000, 16'hFFFF, 5'd0, 15'd0, 1'b0}},
    '{ROW_PIXEL, REG_GAIN_RED, 21'd0, 1'b0, 8'd3, 8'd7, 8'd9, 1'b0, UNTYPED},
    '{ROW_PIXEL, REG_GAIN_RED, 21'd0, 1'b0, 8'd255, 8'd128, 8'd64, 1'b0, UNTYPED},
    '{ROW_PIXEL, REG_GAIN_RED, 21'd0, 1'b0, 8'd17, 8'd34, 8'd51, 1'b0, UNTYPED},
    '{ROW_PIXEL, REG_GAIN_RED, 21'd0, 1'b0, 8'd200, 8'd100, 8'd50, 1'b0, UNTYPED},
    '{ROW_WRITE, REG_PATCH_SIZE, 21'd2, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, UNTYPED},
    '{ROW_PIXEL, REG_GAIN_RED, 21'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, UNTYPED},
    '{ROW_PIXEL, REG_GAIN_RED, 21'd0, 1'b0, 8'd10, 8'd20, 8'd30, 1'b0, UNTYPED},
    '{ROW_PIXEL, REG_GAIN_RED, 21'd0, 1'b0, 8'd90, 8'd80, 8'd70, 1'b0, UNTYPED},
    '{ROW_PIXEL, REG_GAIN_RED, 21'd0, 1'b0, 8'd255, 8'd255, 8'd255, 1'b0, UNTYPED},
    '{ROW_WRITE, REG_WIDTH_PATCH, 21'd1, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, UNTYPED},
    '{ROW_PIXEL, REG_GAIN_RED, 21'd0, 1'b0, 8'd1, 8'd2, 8'd3, 1'b0, UNTYPED},
    '{ROW_PIXEL, REG_GAIN_RED, 21'd0, 1'b0, 8'd4, 8'd5, 8'd6, 1'b0, UNTYPED},
    '{ROW_PIXEL, REG_GAIN_RED, 21'd0, 1'b0, 8'd7, 8'd8, 8'd9, 1'b0, UNTYPED},
    '{ROW_PIXEL, REG_GAIN_RED, 21'd0, 1'b0, 8'd250, 8'd251, 8'd252, 1'b0, UNTYPED}
  };

  // p*gain + offset in Q.16, rounded half up to Q4.12 and saturated
  function automatic logic [15:0] scale_channel(logic [7:0] pix, logic [15:0] gain,
                                                logic [20:0] off);
    longint acc;
    longint q;
    acc = longint'(pix) * longint'(gain) + longint'($signed(off)) + 8;
    q = acc >>> 4;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  // expected result of one accepted pixel; advances the raster position
  function automatic norm_result_t normalize_and_place(logic sof, logic [7:0] r, g, b);
    norm_result_t res;
    int ps;
    int wp;
    int pidx;
    ps = (patch_reg == 0) ? 1 : (patch_reg > MAX_PATCH_SIZE) ? MAX_PATCH_SIZE : int'(patch_reg);
    wp = (width_reg == 0) ? 1 : (width_reg > MAX_PATCHES) ? MAX_PATCHES : int'(width_reg);
    if (sof) begin
      px_col = 0;
      px_patch_col = 0;
      px_row = 0;
      px_row_base = 0;
    end
    res.red   = scale_channel(r, gain_q[0], offset_q[0]);
    res.green = scale_channel(g, gain_q[1], offset_q[1]);
    res.blue  = scale_channel(b, gain_q[2], offset_q[2]);
    pidx = px_row_base + px_patch_col;
    res.ovf = (pidx >= MAX_PATCHES);
    res.row = 5'(px_row);
    res.col = res.ovf ? 15'd0 : 15'(pidx * ps + px_col);
    // raster advance; a counter past a shrunken bound wraps here
    if (px_col + 1 >= ps) begin
      px_col = 0;
      if (px_patch_col + 1 >= wp) begin
        px_patch_col = 0;
        if (px_row + 1 >= ps) begin
          px_row = 0;
          px_row_base = px_row_base + wp;
          if (px_row_base > 65535) px_row_base = 65535;
        end else begin
          px_row = px_row + 1;
        end
      end else begin
        px_patch_col = px_patch_col + 1;
      end
    end else begin
      px_col = px_col + 1;
    end
    return res;
  endfunction

  // mirror a register write into the predictor
  function automatic void note_write(cfg_reg_t idx, logic [20:0] v);
    case (idx)
      REG_GAIN_RED:     gain_q[0] = v[15:0];
      REG_GAIN_GREEN:   gain_q[1] = v[15:0];
      REG_GAIN_BLUE:    gain_q[2] = v[15:0];
      REG_OFFSET_RED:   offset_q[0] = v;
      REG_OFFSET_GREEN: offset_q[1] = v;
      REG_OFFSET_BLUE:  offset_q[2] = v;
      REG_PATCH_SIZE:   patch_reg = v[5:0];
      REG_WIDTH_PATCH:  width_reg = v[10:0];
      default: ;
    endcase
  endfunction

  // random register value, weighted toward extremes and usable sizes
  function automatic logic [20:0] pick_setting(cfg_reg_t idx);
    logic [20:0] v;
    case (idx)
      REG_GAIN_RED, REG_GAIN_GREEN, REG_GAIN_BLUE: begin
        case ($urandom_range(0, 5))
          0: v = 21'd0;
          1: v = 21'd65535;
          2: v = 21'($urandom_range(900, 1200));
          default: v = 21'($urandom_range(0, 65535));
        endcase
      end
      REG_OFFSET_RED, REG_OFFSET_GREEN, REG_OFFSET_BLUE: begin
        case ($urandom_range(0, 5))
          0: v = 21'h100000;
          1: v = 21'h0FFFFF;
          2: v = 21'(-int'($urandom_range(0, 200000)));
          default: v = 21'($urandom());
        endcase
      end
      REG_PATCH_SIZE: begin
        case ($urandom_range(0, 15))
          0: v = 21'd0;
          1: v = 21'd32;
          2: v = 21'($urandom_range(33, 63));
          3: v = 21'd14;
          default: v = 21'($urandom_range(1, 6));
        endcase
      end
      default: begin
        case ($urandom_range(0, 15))
          0: v = 21'd0;
          1: v = 21'd1024;
          2: v = 21'($urandom_range(1025, 2047));
          3: v = 21'($urandom_range(5, 40));
          default: v = 21'($urandom_range(1, 4));
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic void report_miss(string text);
    miss_count++;
    if (miss_count <= 10) $display("%0t mismatch: %s", $time, text);
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) report_miss($sformatf("%s expected %h, got %h", name, want, got));
  endfunction

  // one pixel request, optionally after a random gap; starts and ends at a falling edge
  task automatic push_pixel(input logic sof, input logic [7:0] r, g, b, input logic typed,
                            input norm_result_t golden);
    norm_result_t predicted;
    if (source_gaps && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {b, g, r};
    in_tuser  = sof;
    do @(posedge clk); while (!in_tready);
    predicted = normalize_and_place(sof, r, g, b);
    expected_norm.insert(expected_norm.size(), typed ? golden : predicted);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [20:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    note_write(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (expected_norm.size() != 0) @(negedge clk);
  endtask

  // result side: random stall bursts, plus one long hold on request
  initial begin
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // result checker against the oldest expectation
  always @(posedge clk) begin
    norm_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_norm.size() == 0) begin
        report_miss($sformatf("result with none pending: data %h user %h",
                              out_tdata, out_tuser));
      end else begin
        want = expected_norm.pop_front();
        compare_field("norm_red", want.red, out_tdata[15:0]);
        compare_field("norm_green", want.green, out_tdata[31:16]);
        compare_field("norm_blue", want.blue, out_tdata[47:32]);
        compare_field("strip_row", 16'(want.row), 16'(out_tdata[52:48]));
        compare_field("strip_col", 16'(want.col), 16'(out_tdata[67:53]));
        compare_field("index_overflow", 16'(want.ovf), 16'(out_tuser[0]));
      end
    end
  end

  // stimulus
  initial begin
    int          phase;
    int          n_items;
    int          n_writes;
    int          waited;
    bit          restart;
    bit          calm;
    cfg_reg_t    idx;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    gain_q    = '{GAIN_RST, GAIN_RST, GAIN_RST};
    offset_q  = '{OFF_RST, OFF_RST, OFF_RST};
    patch_reg = PSZ_RST;
    width_reg = WIP_RST;
    px_col = 0;
    px_patch_col = 0;
    px_row = 0;
    px_row_base = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        push_pixel(directed_rows[i].sof, directed_rows[i].red, directed_rows[i].green,
                   directed_rows[i].blue, directed_rows[i].typed, directed_rows[i].golden);
      end
    end

    // random phases: new settings while idle, then images with random content
    for (phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      calm = (phase >= PHASES - 2);
      source_gaps = !calm && ($urandom_range(0, 3) != 0);
      sink_gaps   = !calm && ($urandom_range(0, 3) != 0);
      if (phase == 5) begin
        // one patch per pixel: the patch index runs past the storage bound
        write_reg(REG_PATCH_SIZE, 21'd1);
        write_reg(REG_WIDTH_PATCH, 21'($urandom_range(1024, 2047)));
        n_items = 1040;
        restart = 1'b1;
      end else begin
        n_writes = $urandom_range(1, 8);
        repeat (n_writes) begin
          idx = cfg_reg_t'($urandom_range(0, 7));
          write_reg(idx, pick_setting(idx));
        end
        n_items = (phase == 2) ? 24 : $urandom_range(4, 10);
        restart = ($urandom_range(0, 3) != 0);
      end
      // long output hold while requests keep coming
      if (phase == 2) begin
        source_gaps = 1'b0;
        sink_gaps   = 1'b0;
      end
      for (int k = 0; k < n_items; k++) begin
        if (phase == 2 && k == 2) hold_req = 1'b1;
        push_pixel((k == 0 && restart) || (phase != 5 && $urandom_range(0, 39) == 0),
                   pick_byte(), pick_byte(), pick_byte(), 1'b0, UNTYPED);
      end
    end

    // final drain
    in_tvalid = 1'b0;
    waited = 0;
    while (expected_norm.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
    if (expected_norm.size() != 0)
      report_miss($sformatf("%0d results never arrived", expected_norm.size()));
    if (miss_count == 0) begin
      $display("pixel_normalize_patch_reshape_tb: done, clean");
    end else begin
      $display("pixel_normalize_patch_reshape_tb: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("pixel_normalize_patch_reshape_tb: done, errors");
    $finish;
  end

endmodule

[files.f]
src/pnpr_pkg.sv
src/pnpr_norm.sv
src/pixel_normalize_patch_reshape.sv
tb/sv/pixel_normalize_patch_reshape_tb.sv
